// ===== rtl/rmq_pkg.sv =====
// shared types and constants for the rotation matrix to quaternion converter
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int SQ_CELLS  = 16;
    localparam int DV_CELLS  = 17;
    localparam int LATENCY   = SQ_CELLS + DV_CELLS + 3;

    localparam logic [1:0] OWN_W = 2'd0;
    localparam logic [1:0] OWN_X = 2'd1;
    localparam logic [1:0] OWN_Y = 2'd2;
    localparam logic [1:0] OWN_Z = 2'd3;

    typedef struct packed {
        logic              valid;
        logic [31:0]       x;
        logic [18:0]       rem;
        logic [15:0]       root;
        logic [1:0]        own;
        logic [3:0][16:0]  num;
    } t_sq;

    typedef struct packed {
        logic        neg;
        logic        nz;
        logic        ovf;
        logic [16:0] n;
        logic [16:0] p;
        logic [16:0] q;
    } t_lane;

    typedef struct packed {
        logic            valid;
        logic [1:0]      own;
        logic [15:0]     r;
        logic [16:0]     d;
        t_lane [3:0]     lane;
    } t_dv;

endpackage

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// rotation matrix to unit quaternion: branch select, root chain, divider chain, saturation
// pipeline: 1 setup register, 16 root cells, 1 divisor setup register,
// 17 divider cells, 1 output register
// throughput: one matrix per cycle, busy is always low
// results appear for one cycle on o_valid and cannot be stalled
// synchronous active-low reset clears all valid flags in the cell chains
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_m11,
    input  logic signed [15:0] i_m12,
    input  logic signed [15:0] i_m13,
    input  logic signed [15:0] i_m21,
    input  logic signed [15:0] i_m22,
    input  logic signed [15:0] i_m23,
    input  logic signed [15:0] i_m31,
    input  logic signed [15:0] i_m32,
    input  logic signed [15:0] i_m33,
    output logic               o_valid,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z,
    output logic               o_degenerate
);

    localparam logic signed [17:0] ONE = 18'sd1 <<< FRAC_BITS;

    t_sq sq [SQ_CELLS+1];
    t_dv dv [DV_CELLS+1];

    t_sq                r_sq0;
    t_sq                n_sq0;
    logic signed [17:0] a11, a12, a13, a21, a22, a23, a31, a32, a33;
    logic signed [17:0] trace;
    logic signed [17:0] arg;
    logic [3:0][17:0]   nm;

    assign busy = 1'b0;

    always_comb begin
        a11 = 18'(i_m11); a12 = 18'(i_m12); a13 = 18'(i_m13);
        a21 = 18'(i_m21); a22 = 18'(i_m22); a23 = 18'(i_m23);
        a31 = 18'(i_m31); a32 = 18'(i_m32); a33 = 18'(i_m33);
        trace = a11 + a22 + a33;
        nm    = '0;
        n_sq0 = '0;
        priority if (trace > 0) begin
            arg       = ONE + trace;
            n_sq0.own = OWN_W;
            nm[1] = a32 - a23; nm[2] = a13 - a31; nm[3] = a21 - a12;
        end else if (a11 > a22 && a11 > a33) begin
            arg       = ONE + a11 - a22 - a33;
            n_sq0.own = OWN_X;
            nm[0] = a32 - a23; nm[2] = a12 + a21; nm[3] = a13 + a31;
        end else if (a22 > a33) begin
            arg       = ONE + a22 - a11 - a33;
            n_sq0.own = OWN_Y;
            nm[0] = a13 - a31; nm[1] = a12 + a21; nm[3] = a23 + a32;
        end else begin
            arg       = ONE + a33 - a11 - a22;
            n_sq0.own = OWN_Z;
            nm[0] = a21 - a12; nm[1] = a13 + a31; nm[2] = a23 + a32;
        end
        n_sq0.valid = start;
        n_sq0.x     = arg[17] ? '0 : {1'b0, arg[16:0], 14'b0};
        for (int k = 0; k < 4; k++) begin
            n_sq0.num[k] = nm[k][16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq0.valid <= 1'b0;
        end else begin
            r_sq0 <= n_sq0;
        end
    end

    assign sq[0] = r_sq0;

    for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sq
        rmq_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (sq[g]),
            .o_d     (sq[g+1])
        );
    end

    // divisor setup and overflow precheck
    t_dv         r_dv0;
    t_dv         n_dv0;
    logic [3:0][30:0] mag;
    logic [16:0] ab;

    always_comb begin
        n_dv0       = '0;
        n_dv0.valid = sq[SQ_CELLS].valid;
        n_dv0.own   = sq[SQ_CELLS].own;
        n_dv0.r     = sq[SQ_CELLS].root;
        n_dv0.d     = {sq[SQ_CELLS].root, 1'b0};
        for (int k = 0; k < 4; k++) begin
            ab     = sq[SQ_CELLS].num[k][16] ? 17'(-sq[SQ_CELLS].num[k])
                                              : sq[SQ_CELLS].num[k];
            mag[k] = {ab, 14'b0};
            n_dv0.lane[k].neg = sq[SQ_CELLS].num[k][16];
            n_dv0.lane[k].nz  = |sq[SQ_CELLS].num[k];
            n_dv0.lane[k].ovf = {3'b0, mag[k]} >= {n_dv0.d, 17'b0};
            n_dv0.lane[k].p   = {3'b0, mag[k][30:17]};
            n_dv0.lane[k].n   = mag[k][16:0];
            n_dv0.lane[k].q   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0.valid <= 1'b0;
        end else begin
            r_dv0 <= n_dv0;
        end
    end

    assign dv[0] = r_dv0;

    for (genvar g = 0; g < DV_CELLS; g++) begin : g_dv
        rmq_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_d     (dv[g]),
            .o_d     (dv[g+1])
        );
    end

    // sign, saturation and own component
    t_dv              fin;
    logic [3:0][15:0] n_q;
    logic             n_degen;
    logic             zr;
    logic [3:0][15:0] r_q;
    logic             r_valid;
    logic             r_degen;

    always_comb begin
        fin     = dv[DV_CELLS];
        zr      = (fin.r == '0);
        n_degen = zr;
        for (int k = 0; k < 4; k++) begin
            if (2'(k) == fin.own) begin
                n_q[k] = {1'b0, fin.r[15:1]};
            end else if (!fin.lane[k].nz) begin
                n_q[k] = '0;
            end else if (zr || fin.lane[k].ovf) begin
                n_q[k] = fin.lane[k].neg ? 16'h8000 : 16'h7fff;
            end else if (!fin.lane[k].neg) begin
                n_q[k] = (fin.lane[k].q > 17'd32767) ? 16'h7fff : fin.lane[k].q[15:0];
            end else begin
                n_q[k] = (fin.lane[k].q > 17'd32768) ? 16'h8000
                                                    : 16'(-fin.lane[k].q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_degen <= 1'b0;
        end else begin
            r_q     <= n_q;
            r_degen <= n_degen & fin.valid;
            r_valid <= fin.valid;
        end
    end

    assign o_valid      = r_valid;
    assign o_degenerate = r_degen;
    assign o_quat_w     = r_q[0];
    assign o_quat_x     = r_q[1];
    assign o_quat_y     = r_q[2];
    assign o_quat_z     = r_q[3];

    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n, LATENCY) |-> (o_valid == $past(start, LATENCY)))
        else $error("result strobe does not follow start by the pipeline latency");

    a_deg : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_degenerate |-> o_valid)
        else $error("degenerate flag without a result");

    // a zero root leaves the own component at zero
    a_degw : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_quat_w == 16'sd0 || o_quat_x == 16'sd0
            || o_quat_y == 16'sd0 || o_quat_z == 16'sd0))
        else $error("degenerate result malformed");

endmodule

// ===== rtl/rmq_sqrt_cell.sv =====
// one digit of the restoring square root
module rmq_sqrt_cell
    import rmq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sq  i_d,
    output t_sq  o_d
);

    t_sq         r_d;
    t_sq         n_d;
    logic [18:0] rem2;
    logic [18:0] trial;

    always_comb begin
        n_d   = i_d;
        rem2  = {i_d.rem[16:0], i_d.x[31:30]};
        trial = {1'b0, i_d.root, 2'b01};
        n_d.x = {i_d.x[29:0], 2'b00};
        if (rem2 >= trial) begin
            n_d.rem  = rem2 - trial;
            n_d.root = {i_d.root[14:0], 1'b1};
        end else begin
            n_d.rem  = rem2;
            n_d.root = {i_d.root[14:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ===== rtl/rmq_div_cell.sv =====
// one quotient bit of four restoring dividers sharing a divisor
module rmq_div_cell
    import rmq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_dv  i_d,
    output t_dv  o_d
);

    t_dv         r_d;
    t_dv         n_d;
    logic [3:0][17:0] p2;

    always_comb begin
        n_d = i_d;
        for (int k = 0; k < 4; k++) begin
            p2[k] = {i_d.lane[k].p, i_d.lane[k].n[16]};
            n_d.lane[k].n = {i_d.lane[k].n[15:0], 1'b0};
            if (p2[k] >= {1'b0, i_d.d}) begin
                n_d.lane[k].p = 17'(p2[k] - {1'b0, i_d.d});
                n_d.lane[k].q = {i_d.lane[k].q[15:0], 1'b1};
            end else begin
                n_d.lane[k].p = p2[k][16:0];
                n_d.lane[k].q = {i_d.lane[k].q[15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule
